// ===== design/bpsp_pkg.sv =====
// Shared types and constants for the ball plate servo PI controller.
`default_nettype none

package bpsp_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_RUN_MODE = 3'd0;
  localparam logic [2:0] REG_TARGET_X = 3'd1;
  localparam logic [2:0] REG_TARGET_Y = 3'd2;
  localparam logic [2:0] REG_CAP_OFS  = 3'd3;
  localparam logic [2:0] REG_CENTER_X = 3'd4;
  localparam logic [2:0] REG_CENTER_Y = 3'd5;

  localparam logic [14:0] GAIN_STEP = 15'd24;
  localparam logic [14:0] GAIN_MAX  = 15'd9000;

  localparam logic [14:0] SX_MIN = 15'd10000;
  localparam logic [14:0] SX_MAX = 15'd17300;
  localparam logic [14:0] SY_MIN = 15'd10320;
  localparam logic [14:0] SY_MAX = 15'd15280;

  // floor(u / 100) = (u * DIV_MULT) >> DIV_SHIFT, low by at most one
  localparam int           DIV_SHIFT = 28;
  localparam logic [21:0]  DIV_MULT  = 22'd2684354;
  localparam logic [16:0]  DIV_BIAS  = 17'd14000;
  localparam logic [24:0]  PROD_BIAS = 25'd1400000;

  typedef struct packed {
    logic        run_mode;
    logic [6:0]  target_x;
    logic [6:0]  target_y;
    logic [7:0]  gain_cap_offset;
    logic [14:0] center_x;
    logic [14:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
    logic s7;
    logic s8;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== design/bpsp_regs.sv =====
// APB register file holding the controller configuration.
`default_nettype none

module bpsp_regs
  import bpsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output cfg_t                       cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[4:2];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_mode        <= 1'b0;
      cfg.target_x        <= 7'd3;
      cfg.target_y        <= 7'd26;
      cfg.gain_cap_offset <= 8'd0;
      cfg.center_x        <= 15'd13790;
      cfg.center_y        <= 15'd12600;
    end else if (wr) begin
      case (idx)
        REG_RUN_MODE: cfg.run_mode        <= pwdata[0];
        REG_TARGET_X: cfg.target_x        <= pwdata[6:0];
        REG_TARGET_Y: cfg.target_y        <= pwdata[6:0];
        REG_CAP_OFS:  cfg.gain_cap_offset <= pwdata[7:0];
        REG_CENTER_X: cfg.center_x        <= pwdata[14:0];
        REG_CENTER_Y: cfg.center_y        <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RUN_MODE: prdata = {31'd0, cfg.run_mode};
      REG_TARGET_X: prdata = {25'd0, cfg.target_x};
      REG_TARGET_Y: prdata = {25'd0, cfg.target_y};
      REG_CAP_OFS:  prdata = {24'd0, cfg.gain_cap_offset};
      REG_CENTER_X: prdata = {17'd0, cfg.center_x};
      REG_CENTER_Y: prdata = {17'd0, cfg.center_y};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/bpsp_chan.sv =====
// One servo axis: gain times error plus 100 times the integral, truncating divide by 100, center offset and clamp.
`default_nettype none

module bpsp_chan
  import bpsp_pkg::*;
#(
  parameter int INTEGRAL_BITS = 24
) (
  input  wire logic                            clk,
  input  wire stage_en_t                       en,
  input  wire logic        [14:0]              gain,
  input  wire logic signed [8:0]               err,
  input  wire logic signed [INTEGRAL_BITS-1:0] integral,
  input  wire logic        [14:0]              center,
  input  wire logic                            negate,
  input  wire logic        [14:0]              lo,
  input  wire logic        [14:0]              hi,
  input  wire logic                            drive,
  output logic             [14:0]              servo
);

  localparam int IW = INTEGRAL_BITS;
  localparam int AW = IW + 2;
  localparam int SW = AW + 2;

  logic signed [24:0]   p4;
  logic signed [IW-1:0] i4, i5, i6;
  logic        [21:0]   u5;
  logic        [43:0]   prod5;
  logic signed [16:0]   q6;
  logic                 rnz6;
  logic signed [AW-1:0] a7;
  logic                 rnz7;

  logic        [21:0]   u4;
  logic        [15:0]   qe;
  logic        [22:0]   qe_x100;
  logic        [22:0]   r_full;
  logic        [7:0]    r8;
  logic                 over;
  logic        [15:0]   qadj;
  logic signed [AW:0]   cnt;
  logic signed [SW-1:0] ctr;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] lo_s, hi_s;
  logic        [14:0]   clamped;

  assign u4 = 22'(p4 + $signed(PROD_BIAS));

  assign qe      = prod5[DIV_SHIFT+15:DIV_SHIFT];
  assign qe_x100 = {7'd0, qe} * 23'd100;
  assign r_full  = {1'b0, u5} - qe_x100;
  assign r8      = r_full[7:0];
  assign over    = r8 >= 8'd100;
  assign qadj    = qe + {15'd0, over};

  assign cnt  = {a7[AW-1], a7} + (((a7 < 0) && rnz7) ? (AW+1)'(1) : (AW+1)'(0));
  assign ctr  = $signed({{(SW-15){1'b0}}, center});
  assign sum  = negate ? (ctr - SW'(cnt)) : (ctr + SW'(cnt));
  assign lo_s = $signed({{(SW-15){1'b0}}, lo});
  assign hi_s = $signed({{(SW-15){1'b0}}, hi});

  always_comb begin
    if (sum < lo_s) begin
      clamped = lo;
    end else if (sum > hi_s) begin
      clamped = hi;
    end else begin
      clamped = sum[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      p4 <= $signed({1'b0, gain}) * err;
      i4 <= integral;
    end
    if (en.s5) begin
      u5    <= u4;
      prod5 <= u4 * DIV_MULT;
      i5    <= i4;
    end
    if (en.s6) begin
      q6   <= $signed({1'b0, qadj}) - $signed(DIV_BIAS);
      rnz6 <= over ? (r8 != 8'd100) : (r8 != 8'd0);
      i6   <= i5;
    end
    if (en.s7) begin
      a7   <= $signed({{2{i6[IW-1]}}, i6}) + $signed({{(AW-17){q6[16]}}, q6});
      rnz7 <= rnz6;
    end
    if (en.s8) begin
      servo <= drive ? clamped : 15'd0;
    end
  end

endmodule

`default_nettype wire

// ===== design/ball_plate_servo_pid.sv =====
// Top level of the two-axis gain-scheduled PI servo controller for a ball plate.
//
// Usage: one input transaction per camera frame on the s_axis channel carries
// the detected ball column and row plus the integrate and clear flags. Each
// input transaction yields exactly one output transaction on m_axis: tuser is
// the drive flag, tdata carries both servo duties and the ball position.
// A zero column or row means no ball; the result is then all zero and the
// controller state keeps its value apart from a clear request.
// The datapath is an eight-stage pipeline; the gain and integral registers
// update as each transaction passes the third stage, so one transaction per cycle
// is taken while the output is not stalled. Each stage holds its transaction
// while the next one is stalled, so with m_axis_tready low the pipeline fills
// and s_axis_tready falls only when the input stage is occupied. Synchronous
// reset empties the pipeline, zeroes gains and integrals and loads the register
// defaults. Configuration goes through the APB port (pready always high); the
// user must write it only while the pipeline is empty; the block does not check.
`default_nettype none

module ball_plate_servo_pid
  import bpsp_pkg::*;
#(
  parameter int INTEGRAL_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // raw_col[6:0], raw_row[12:7], integrate_on[13], clear_sums[14], zero[15]
  input  wire logic [15:0]           s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // servo_x[14:0], servo_y[28:15], pos_x[35:29], pos_y[41:36], zero[47:42]
  output logic      [47:0]           m_axis_tdata,
  // drive_valid[0]
  output logic                       m_axis_tuser,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int IW = INTEGRAL_BITS;

  typedef struct packed {
    logic             drive;
    logic [6:0]       pos_x;
    logic [5:0]       pos_y;
  } info_t;

  function automatic logic [14:0] cap_of(input logic [7:0] base, input logic [7:0] ofs);
    logic [7:0] diff;
    diff = base - ofs;
    if (ofs >= base) begin
      return 15'd0;
    end
    return {7'd0, diff} * 15'd100;
  endfunction

  function automatic logic [14:0] min15(input logic [14:0] a, input logic [14:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [IW-1:0] sat_int(input logic signed [IW:0] v);
    if (v[IW] != v[IW-1]) begin
      return v[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end
    return v[IW-1:0];
  endfunction

  cfg_t cfg;

  bpsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // stage valids and advance enables
  logic v1, v2, v3, v4, v5, v6, v7;
  logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;
  logic fire2;
  stage_en_t en;

  assign adv8 = !m_axis_tvalid || m_axis_tready;
  assign adv7 = !v7 || adv8;
  assign adv6 = !v6 || adv7;
  assign adv5 = !v5 || adv6;
  assign adv4 = !v4 || adv5;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign s_axis_tready = adv1;
  assign fire2 = v2 && adv3;
  assign en = '{s4: adv4, s5: adv5, s6: adv6, s7: adv7, s8: adv8};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
      if (adv8) m_axis_tvalid <= v7;
    end
  end

  // stage 1: input register
  logic [6:0] col1;
  logic [5:0] row1;
  logic       integ1, clr1;

  always_ff @(posedge clk) begin
    if (adv1) begin
      col1   <= s_axis_tdata[6:0];
      row1   <= s_axis_tdata[12:7];
      integ1 <= s_axis_tdata[13];
      clr1   <= s_axis_tdata[14];
    end
  end

  // stage 1 to 2: position, errors, distance bands
  logic               ball1;
  logic signed [8:0]  x1, ex1;
  logic signed [6:0]  y1;
  logic signed [7:0]  ey1;
  logic signed [17:0] sq_x1, sq_y1, d2_1;
  info_t              info1;

  assign ball1 = (col1 != 7'd0) && (row1 != 6'd0);
  assign x1    = $signed({2'b00, col1}) - 9'sd39;
  assign y1    = 7'sd31 - $signed({1'b0, row1});
  assign ex1   = x1 - $signed({{2{cfg.target_x[6]}}, cfg.target_x});
  assign ey1   = $signed({y1[6], y1}) - $signed({cfg.target_y[6], cfg.target_y});
  assign sq_x1 = ex1 * ex1;
  assign sq_y1 = ey1 * ey1;
  assign d2_1  = sq_x1 + sq_y1;

  assign info1.drive = ball1 && cfg.run_mode;
  assign info1.pos_x = !ball1 ? 7'd0 : ((x1 > 9'sd63) ? 7'd63 : x1[6:0]);
  assign info1.pos_y = ball1 ? y1[5:0] : 6'd0;

  // stage 2
  info_t             info2;
  logic              integ2, clr2, le150_2, ge100_2, le80_2;
  logic signed [8:0] ex2;
  logic signed [7:0] ey2;

  always_ff @(posedge clk) begin
    if (adv2) begin
      info2   <= info1;
      integ2  <= integ1;
      clr2    <= clr1;
      ex2     <= ex1;
      ey2     <= ey1;
      le150_2 <= d2_1 <= 18'sd150;
      ge100_2 <= d2_1 >= 18'sd100;
      le80_2  <= d2_1 <= 18'sd80;
    end
  end

  // stage 2 to 3: controller state update; the state registers are stage 3's payload
  logic        [14:0]   gain_x, gain_y;
  logic signed [IW-1:0] integral_x, integral_y;

  logic        [14:0]   cap150, cap120, cap90, cap_sel;
  logic        [14:0]   ramp_x, ramp_y;
  logic signed [IW-1:0] ixc, iyc;
  logic signed [15:0]   inc_x, inc_y;
  logic signed [IW:0]   sum_x, sum_y;

  assign cap150  = cap_of(8'd150, cfg.gain_cap_offset);
  assign cap120  = cap_of(8'd120, cfg.gain_cap_offset);
  assign cap90   = cap_of(8'd90, cfg.gain_cap_offset);
  assign cap_sel = !le150_2 ? cap90 : (ge100_2 ? min15(cap150, cap120) : cap150);

  assign ramp_x = min15(gain_x + GAIN_STEP, GAIN_MAX);
  assign ramp_y = min15(gain_y + GAIN_STEP, GAIN_MAX);

  assign ixc   = clr2 ? '0 : integral_x;
  assign iyc   = clr2 ? '0 : integral_y;
  assign inc_x = $signed({{7{ex2[8]}}, ex2}) * (le80_2 ? 16'sd60 : 16'sd10);
  assign inc_y = $signed({{8{ey2[7]}}, ey2}) * (le80_2 ? 16'sd50 : 16'sd10);
  assign sum_x = $signed({ixc[IW-1], ixc}) + $signed({{(IW+1-16){inc_x[15]}}, inc_x});
  assign sum_y = $signed({iyc[IW-1], iyc}) + $signed({{(IW+1-16){inc_y[15]}}, inc_y});

  info_t             info3;
  logic signed [8:0] ex3;
  logic signed [7:0] ey3;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x     <= 15'd0;
      gain_y     <= 15'd0;
      integral_x <= '0;
      integral_y <= '0;
    end else if (fire2) begin
      if (info2.drive) begin
        gain_x <= min15(ramp_x, cap_sel);
        gain_y <= min15(ramp_y, cap_sel);
      end
      if (info2.drive && integ2) begin
        integral_x <= sat_int(sum_x);
        integral_y <= sat_int(sum_y);
      end else begin
        integral_x <= ixc;
        integral_y <= iyc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      info3 <= info2;
      ex3   <= ex2;
      ey3   <= ey2;
    end
  end

  // stages 4 to 8: per-axis servo arithmetic
  info_t info4, info5, info6, info7;

  always_ff @(posedge clk) begin
    if (adv4) info4 <= info3;
    if (adv5) info5 <= info4;
    if (adv6) info6 <= info5;
    if (adv7) info7 <= info6;
  end

  logic [14:0] servo_x, servo_y;

  bpsp_chan #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_chan_x (
    .clk      (clk),
    .en       (en),
    .gain     (gain_x),
    .err      (ex3),
    .integral (integral_x),
    .center   (cfg.center_x),
    .negate   (1'b0),
    .lo       (SX_MIN),
    .hi       (SX_MAX),
    .drive    (info7.drive),
    .servo    (servo_x)
  );

  bpsp_chan #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_chan_y (
    .clk      (clk),
    .en       (en),
    .gain     (gain_y),
    .err      ({ey3[7], ey3}),
    .integral (integral_y),
    .center   (cfg.center_y),
    .negate   (1'b1),
    .lo       (SY_MIN),
    .hi       (SY_MAX),
    .drive    (info7.drive),
    .servo    (servo_y)
  );

  logic [6:0] pos_x8;
  logic [5:0] pos_y8;

  always_ff @(posedge clk) begin
    if (adv8) begin
      m_axis_tuser <= info7.drive;
      pos_x8       <= info7.pos_x;
      pos_y8       <= info7.pos_y;
    end
  end

  assign m_axis_tdata = {6'd0, pos_y8, pos_x8, servo_y[13:0], servo_x};

  // checks
  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (gain_x <= GAIN_MAX) && (gain_y <= GAIN_MAX))
    else $error("gain above maximum");

  a_gain_hold: assert property (@(posedge clk) disable iff (rst)
    !fire2 |=> $stable(gain_x) && $stable(gain_y) && $stable(integral_x)
               && $stable(integral_y))
    else $error("controller state changed without a transaction");

  a_servo_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[14:0] >= SX_MIN) && (m_axis_tdata[14:0] <= SX_MAX)
      && ({1'b0, m_axis_tdata[28:15]} >= SY_MIN)
      && ({1'b0, m_axis_tdata[28:15]} <= SY_MAX))
    else $error("servo duty out of range");

  a_no_drive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[28:0] == 29'd0))
    else $error("servo duty present without drive");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the ball plate servo PI controller.
`timescale 1ns / 1ps

module testbench;
  import bpsp_pkg::*;

  localparam int INT_BITS = 24;

  typedef struct packed {
    logic        drive;
    logic [14:0] servo_x;
    logic [13:0] servo_y;
    logic [6:0]  pos_x;
    logic [5:0]  pos_y;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_valid = 1'b0;
  logic [15:0]           s_data = '0;
  logic                  m_ready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  wire                   s_ready;
  wire                   m_valid;
  wire  [47:0]           m_data;
  wire                   m_user;
  wire  [31:0]           prdata;
  wire                   pready;

  ball_plate_servo_pid #(
    .INTEGRAL_BITS(INT_BITS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  cfg_t        cfg = '{run_mode: 1'b0, target_x: 7'd3, target_y: 7'd26, gain_cap_offset: 8'd0,
                       center_x: 15'd13790, center_y: 15'd12600};
  longint      gain_x = 0;
  longint      gain_y = 0;
  longint      sum_x = 0;
  longint      sum_y = 0;
  logic [15:0] frame_queue[$];
  drive_t      drives_due[$];
  int          errors = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  bit          src_burst = 1'b0;
  bit          sink_burst = 1'b0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_sum(input longint v);
    longint lim;
    lim = (longint'(1) << (INT_BITS - 1)) - 1;
    return clip(v, -lim - 1, lim);
  endfunction

  function automatic void cap_gains(input longint base);
    longint lim;
    lim = (base - longint'(cfg.gain_cap_offset)) * 100;
    if (lim < 0) lim = 0;
    if (gain_x > lim) gain_x = lim;
    if (gain_y > lim) gain_y = lim;
  endfunction

  function automatic drive_t predict_drive(input logic [15:0] item);
    drive_t r;
    longint x, y, ex, ey, d2, tx, ty, cnt;
    r = '0;
    if (item[14]) begin
      sum_x = 0;
      sum_y = 0;
    end
    if (item[6:0] == 0 || item[12:7] == 0) return r;
    x = longint'(item[6:0]) - 39;
    y = 31 - longint'(item[12:7]);
    r.pos_x = 7'(clip(x, -64, 63));
    r.pos_y = 6'(y);
    if (!cfg.run_mode) return r;
    tx = $signed(cfg.target_x);
    ty = $signed(cfg.target_y);
    ex = x - tx;
    ey = y - ty;
    d2 = ex * ex + ey * ey;
    gain_x = clip(gain_x + longint'(GAIN_STEP), 0, GAIN_MAX);
    gain_y = clip(gain_y + longint'(GAIN_STEP), 0, GAIN_MAX);
    if (d2 <= 150) begin
      cap_gains(150);
      if (d2 >= 100) cap_gains(120);
    end else begin
      cap_gains(90);
    end
    if (item[13]) begin
      sum_x = sat_sum(sum_x + (d2 <= 80 ? 60 : 10) * ex);
      sum_y = sat_sum(sum_y + (d2 <= 80 ? 50 : 10) * ey);
    end
    cnt = (gain_x * ex + 100 * sum_x) / 100;
    r.servo_x = 15'(clip(longint'(cfg.center_x) + cnt, SX_MIN, SX_MAX));
    cnt = (gain_y * ey + 100 * sum_y) / 100;
    r.servo_y = 14'(clip(longint'(cfg.center_y) - cnt, SY_MIN, SY_MAX));
    r.drive = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] pack_item(input int col, input int row, input bit integ,
                                            input bit clr);
    return {1'b0, clr, integ, row[5:0], col[6:0]};
  endfunction

  function automatic logic [15:0] random_item();
    int sel, col, row;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      // ball around the target, spans all distance bands
      col = 39 + int'($signed(cfg.target_x)) + int'($urandom_range(0, 24)) - 12;
      row = 31 - int'($signed(cfg.target_y)) - int'($urandom_range(0, 24)) + 12;
      col = int'(clip(col, 1, 127));
      row = int'(clip(row, 1, 63));
    end else if (sel < 80) begin
      col = $urandom_range(1, 79);
      row = $urandom_range(1, 59);
    end else if (sel < 92) begin
      col = $urandom_range(0, 127);
      row = $urandom_range(0, 63);
    end else begin
      col = $urandom_range(0, 127);
      row = $urandom_range(0, 63);
      if ($urandom_range(0, 1)) col = 0;
      else row = 0;
    end
    return pack_item(col, row, $urandom_range(0, 9) < 6, $urandom_range(0, 19) == 0);
  endfunction

  function automatic int idle_len(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic check_field(input string what, input logic [14:0] want, input logic [14:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  task automatic check_drive();
    drive_t want;
    if (drives_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected transaction tdata=%h tuser=%b", $time, m_data, m_user);
    end else begin
      want = drives_due.pop_front();
      check_field("drive_valid", 15'(want.drive), 15'(m_user));
      check_field("servo_x", want.servo_x, m_data[14:0]);
      check_field("servo_y", 15'(want.servo_y), 15'(m_data[28:15]));
      check_field("pos_x", 15'(want.pos_x), 15'(m_data[35:29]));
      check_field("pos_y", 15'(want.pos_y), 15'(m_data[41:36]));
    end
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (s_valid && s_ready) drives_due.push_back(predict_drive(s_data));
      if (!s_valid || s_ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_valid <= 1'b0;
        end else if (frame_queue.size() != 0) begin
          s_data  <= frame_queue.pop_front();
          s_valid <= 1'b1;
          src_gap <= idle_len(src_burst);
        end else begin
          s_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 299) == 0) src_burst <= !src_burst;
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      m_ready  <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_valid && m_ready) check_drive();
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_ready  <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_gap <= idle_len(sink_burst);
      end
      if ($urandom_range(0, 299) == 0) sink_burst <= !sink_burst;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (frame_queue.size() != 0 || s_valid || drives_due.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RUN_MODE: cfg.run_mode = val[0];
      REG_TARGET_X: cfg.target_x = val[6:0];
      REG_TARGET_Y: cfg.target_y = val[6:0];
      REG_CAP_OFS:  cfg.gain_cap_offset = val[7:0];
      REG_CENTER_X: cfg.center_x = val[14:0];
      REG_CENTER_Y: cfg.center_y = val[14:0];
      default: ;
    endcase
  endtask

  task automatic random_run(input int n);
    repeat (n) frame_queue.push_back(random_item());
    wait_drained();
  endtask

  task automatic set_targets(input int tx, input int ty);
    set_reg(REG_TARGET_X, tx);
    set_reg(REG_TARGET_Y, ty);
  endtask

  task automatic set_centers(input int cx, input int cy);
    set_reg(REG_CENTER_X, cx);
    set_reg(REG_CENTER_Y, cy);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // drive off: position only, no-ball cases
    frame_queue.push_back(pack_item(0, 0, 0, 0));
    frame_queue.push_back(pack_item(0, 59, 1, 1));
    frame_queue.push_back(pack_item(79, 0, 1, 0));
    frame_queue.push_back(pack_item(127, 63, 1, 1));
    frame_queue.push_back(pack_item(1, 1, 0, 0));
    frame_queue.push_back(pack_item(42, 5, 1, 0));
    wait_drained();

    // run mode, default target (3, 26): distance band edges, clears
    set_reg(REG_RUN_MODE, 1);
    frame_queue.push_back(pack_item(42, 5, 1, 0));
    frame_queue.push_back(pack_item(50, 1, 1, 0));
    frame_queue.push_back(pack_item(51, 5, 1, 0));
    frame_queue.push_back(pack_item(46, 12, 1, 0));
    frame_queue.push_back(pack_item(52, 5, 1, 0));
    frame_queue.push_back(pack_item(52, 12, 1, 0));
    frame_queue.push_back(pack_item(54, 2, 1, 0));
    frame_queue.push_back(pack_item(127, 63, 1, 0));
    frame_queue.push_back(pack_item(1, 1, 1, 0));
    frame_queue.push_back(pack_item(0, 30, 0, 1));
    frame_queue.push_back(pack_item(45, 20, 0, 0));
    frame_queue.push_back(pack_item(45, 20, 1, 1));
    frame_queue.push_back(pack_item(127, 0, 1, 0));
    frame_queue.push_back(pack_item(60, 40, 0, 0));
    wait_drained();

    random_run(300);

    set_reg(REG_CAP_OFS, 150);
    set_targets(-40, 40);
    set_centers(10000, 17300);
    random_run(150);

    // caps all negative, targets and centers at their field limits
    set_reg(REG_CAP_OFS, 255);
    set_targets(-64, 63);
    set_centers(0, 32767);
    random_run(100);

    set_reg(REG_CAP_OFS, 100);
    set_targets(40, -40);
    set_centers(17300, 10000);
    random_run(200);

    set_reg(REG_RUN_MODE, 0);
    random_run(100);

    set_reg(REG_RUN_MODE, 1);
    set_reg(REG_CAP_OFS, 0);
    set_targets(0, 0);
    set_centers(13790, 12600);
    random_run(270);

    // drive both integrals positive, then back down, y through zero to negative
    frame_queue.push_back(pack_item(1, 1, 0, 1));
    wait_drained();
    set_targets(-64, -64);
    repeat (40) frame_queue.push_back(pack_item(127, 1, 1, 0));
    wait_drained();
    set_targets(63, 63);
    repeat (40) frame_queue.push_back(pack_item(1, 63, 1, 0));
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0 && drives_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bpsp_pkg.sv
design/bpsp_regs.sv
design/bpsp_chan.sv
design/ball_plate_servo_pid.sv
verif/testbench.sv
